FILE: hw/rtl/psfl_pkg.sv
`default_nettype none

package psfl_pkg;

	localparam int DEF_TABLE_ENTRIES = 16;
	localparam int DEF_MAX_TIMES     = 8;

	localparam int ADDR_W    = 32;
	localparam int TIME_W    = 48;
	localparam int WINDOW_W  = 32;
	localparam int MAXC_W    = 4;
	localparam int IN_DATA_W = 80;
	localparam int OUT_DATA_W = 8;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 32;

	localparam logic [MAXC_W-1:0]   MAXC_RESET   = 4'd4;
	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd30000;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_CONN = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 8'd1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD,
		ST_LOAD,
		ST_EXP,
		ST_CMP,
		ST_WB,
		ST_DECIDE,
		ST_OUT
	} psfl_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/psfl_ram.sv
`default_nettype none

module psfl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/psfl_live_cmp.sv
`default_nettype none

module psfl_live_cmp (
	input  wire logic [psfl_pkg::TIME_W-1:0]   stamp,
	input  wire logic [psfl_pkg::WINDOW_W-1:0] window,
	input  wire logic [psfl_pkg::TIME_W-1:0]   now,
	output      logic                          live
);

	localparam int SUM_W = psfl_pkg::TIME_W + 1;

	logic [SUM_W-1:0] deadline;

	// a stamp stays live while stamp + window is still ahead of now
	assign deadline = SUM_W'(stamp) + SUM_W'(window);
	assign live     = deadline > SUM_W'(now);

endmodule

`default_nettype wire

FILE: hw/rtl/per_source_connect_flood_limiter.sv
`default_nettype none

// Per-source connection flood limiter. Each s beat is one connection attempt
// (source address and a non-decreasing millisecond time); each m beat answers
// it with a flooding flag and a table_full flag. The block tracks up to
// TABLE_ENTRIES sources, each with a ring of up to MAX_TIMES accepted-attempt
// times, and refuses a source that already holds max_connections live times
// within window_ms. For each attempt the sequencer visits every table entry in
// turn through single-port-read memories and one shared time comparator, and
// the new result is held back while the previous one still waits on m_tready;
// s_tready is low meanwhile. After reset a clearing pass over all TABLE_ENTRIES
// entries runs before the first attempt is taken; configuration writes are
// taken at any time.
module per_source_connect_flood_limiter #(
	parameter int TABLE_ENTRIES = psfl_pkg::DEF_TABLE_ENTRIES,
	parameter int MAX_TIMES     = psfl_pkg::DEF_MAX_TIMES
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output      logic                               s_tready,
	input  wire logic [psfl_pkg::IN_DATA_W-1:0]     s_tdata,   // source_address, now_ms
	output      logic                               m_tvalid,
	input  wire logic                               m_tready,
	output      logic [psfl_pkg::OUT_DATA_W-1:0]    m_tdata,   // flooding, table_full
	input  wire logic                               cfg_valid,
	output      logic                               cfg_ready,
	input  wire logic [psfl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [psfl_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int EIDX_W = $clog2(TABLE_ENTRIES);
	localparam int SLOT_W = (MAX_TIMES > 1) ? $clog2(MAX_TIMES) : 1;
	localparam int CNT_W  = $clog2(MAX_TIMES + 1);
	localparam int META_W = SLOT_W + CNT_W;
	localparam int TIDX_W = $clog2(TABLE_ENTRIES * MAX_TIMES);
	localparam int SUM_W  = CNT_W + 1;
	localparam int LIM_W  = (CNT_W > psfl_pkg::MAXC_W) ? CNT_W : psfl_pkg::MAXC_W;

	localparam logic [EIDX_W-1:0] LAST_E    = EIDX_W'(TABLE_ENTRIES - 1);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_TIMES - 1);
	localparam logic [SUM_W-1:0]  RING      = SUM_W'(MAX_TIMES);
	localparam logic [LIM_W-1:0]  LIM_MAX   = LIM_W'(MAX_TIMES);

	localparam int ADDR_W = psfl_pkg::ADDR_W;
	localparam int TIME_W = psfl_pkg::TIME_W;

	function automatic logic [TIDX_W-1:0] tidx(input logic [EIDX_W-1:0] e,
		input logic [SLOT_W-1:0] s);
		tidx = TIDX_W'(TIDX_W'(e) * TIDX_W'(MAX_TIMES)) + TIDX_W'(s);
	endfunction

	psfl_pkg::psfl_state_t state_q, state_d;

	logic [psfl_pkg::MAXC_W-1:0]   max_conn_q;
	logic [psfl_pkg::WINDOW_W-1:0] window_q;

	logic [ADDR_W-1:0] addr_q;
	logic [TIME_W-1:0] now_q;
	logic [LIM_W-1:0]  limit_q;
	logic [EIDX_W-1:0] e_q;
	logic [SLOT_W-1:0] head_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ADDR_W-1:0] ent_addr_q;
	logic              found_v_q;
	logic [EIDX_W-1:0] found_q;
	logic [SLOT_W-1:0] fhead_q;
	logic [CNT_W-1:0]  fcnt_q;
	logic              free_v_q;
	logic [EIDX_W-1:0] free_q;
	logic              res_flood_q;
	logic              res_full_q;
	logic              m_tvalid_q;
	logic              m_flood_q;
	logic              m_full_q;

	// memory ports
	logic              meta_we, meta_re;
	logic [EIDX_W-1:0] meta_waddr;
	logic [META_W-1:0] meta_wdata, meta_rdata;
	logic              ea_we, ea_re;
	logic [ADDR_W-1:0] ea_rdata;
	logic              time_we, time_re;
	logic [TIDX_W-1:0] time_waddr, time_raddr;
	logic [TIME_W-1:0] time_rdata;

	logic              live;
	logic              accept;
	logic              out_load;
	logic [LIM_W-1:0]  limit_new;
	logic [SLOT_W-1:0] head_inc, wb_head;
	logic [EIDX_W-1:0] tgt_e;
	logic [SLOT_W-1:0] tgt_h;
	logic [CNT_W-1:0]  tgt_c;
	logic [SUM_W-1:0]  pos_sum, pos;
	logic              over;
	logic              no_entry;

	psfl_ram #(.WIDTH(META_W), .DEPTH(TABLE_ENTRIES)) u_meta (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.re    (meta_re),
		.raddr (e_q),
		.rdata (meta_rdata)
	);

	psfl_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_ENTRIES)) u_ent_addr (
		.clk   (clk),
		.we    (ea_we),
		.waddr (free_q),
		.wdata (addr_q),
		.re    (ea_re),
		.raddr (e_q),
		.rdata (ea_rdata)
	);

	psfl_ram #(.WIDTH(TIME_W), .DEPTH(TABLE_ENTRIES * MAX_TIMES)) u_times (
		.clk   (clk),
		.we    (time_we),
		.waddr (time_waddr),
		.wdata (now_q),
		.re    (time_re),
		.raddr (time_raddr),
		.rdata (time_rdata)
	);

	psfl_live_cmp u_cmp (
		.stamp  (time_rdata),
		.window (window_q),
		.now    (now_q),
		.live   (live)
	);

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == psfl_pkg::ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {6'b0, m_full_q, m_flood_q};

	assign limit_new = (LIM_W'(max_conn_q) > LIM_MAX) ? LIM_MAX : LIM_W'(max_conn_q);
	assign head_inc  = (head_q == LAST_SLOT) ? '0 : head_q + SLOT_W'(1);
	assign wb_head   = (cnt_q == '0) ? '0 : head_q;

	assign no_entry  = !found_v_q && !free_v_q;
	assign tgt_e     = found_v_q ? found_q : free_q;
	assign tgt_h     = found_v_q ? fhead_q : '0;
	assign tgt_c     = found_v_q ? fcnt_q : '0;
	assign pos_sum   = SUM_W'(tgt_h) + SUM_W'(tgt_c);
	assign pos       = (pos_sum >= RING) ? pos_sum - RING : pos_sum;
	assign over      = LIM_W'(tgt_c) >= limit_q;

	assign time_raddr = tidx(e_q, head_q);
	assign time_waddr = tidx(tgt_e, pos[SLOT_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psfl_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		meta_we    = 1'b0;
		meta_re    = 1'b0;
		meta_waddr = e_q;
		meta_wdata = '0;
		ea_we      = 1'b0;
		ea_re      = 1'b0;
		time_we    = 1'b0;
		time_re    = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			psfl_pkg::ST_CLEAR: begin
				meta_we = 1'b1;
				if (e_q == LAST_E) begin
					state_d = psfl_pkg::ST_IDLE;
				end
			end
			psfl_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = psfl_pkg::ST_RD;
				end
			end
			psfl_pkg::ST_RD: begin
				meta_re = 1'b1;
				ea_re   = 1'b1;
				state_d = psfl_pkg::ST_LOAD;
			end
			psfl_pkg::ST_LOAD: begin
				state_d = psfl_pkg::ST_EXP;
			end
			psfl_pkg::ST_EXP: begin
				if (cnt_q == '0) begin
					state_d = psfl_pkg::ST_WB;
				end else begin
					time_re = 1'b1;
					state_d = psfl_pkg::ST_CMP;
				end
			end
			psfl_pkg::ST_CMP: begin
				state_d = live ? psfl_pkg::ST_WB : psfl_pkg::ST_EXP;
			end
			psfl_pkg::ST_WB: begin
				meta_we    = 1'b1;
				meta_wdata = {cnt_q, wb_head};
				state_d    = (e_q == LAST_E) ? psfl_pkg::ST_DECIDE : psfl_pkg::ST_RD;
			end
			psfl_pkg::ST_DECIDE: begin
				// record the attempt unless refused or untracked
				if (!no_entry) begin
					ea_we = !found_v_q;
					if (!over) begin
						meta_we    = 1'b1;
						meta_waddr = tgt_e;
						meta_wdata = {tgt_c + CNT_W'(1), tgt_h};
						time_we    = 1'b1;
					end
				end
				state_d = psfl_pkg::ST_OUT;
			end
			psfl_pkg::ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = psfl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = psfl_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_conn_q <= psfl_pkg::MAXC_RESET;
			window_q   <= psfl_pkg::WINDOW_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				psfl_pkg::REG_MAX_CONN: begin
					max_conn_q <= cfg_data[psfl_pkg::MAXC_W-1:0];
				end
				psfl_pkg::REG_WINDOW: begin
					window_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q        <= '0;
			found_v_q  <= 1'b0;
			free_v_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				psfl_pkg::ST_CLEAR: begin
					e_q <= (e_q == LAST_E) ? '0 : e_q + EIDX_W'(1);
				end
				psfl_pkg::ST_IDLE: begin
					if (accept) begin
						e_q       <= '0;
						found_v_q <= 1'b0;
						free_v_q  <= 1'b0;
					end
				end
				psfl_pkg::ST_WB: begin
					// first live match wins; otherwise note the lowest free entry
					if (cnt_q != '0) begin
						if (!found_v_q && ent_addr_q == addr_q) begin
							found_v_q <= 1'b1;
						end
					end else if (!free_v_q) begin
						free_v_q <= 1'b1;
					end
					if (e_q != LAST_E) begin
						e_q <= e_q + EIDX_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q  <= s_tdata[ADDR_W-1:0];
			now_q   <= s_tdata[ADDR_W+TIME_W-1:ADDR_W];
			limit_q <= limit_new;
		end
		if (state_q == psfl_pkg::ST_LOAD) begin
			head_q     <= meta_rdata[SLOT_W-1:0];
			cnt_q      <= meta_rdata[META_W-1:SLOT_W];
			ent_addr_q <= ea_rdata;
		end
		if (state_q == psfl_pkg::ST_CMP && !live) begin
			head_q <= head_inc;
			cnt_q  <= cnt_q - CNT_W'(1);
		end
		if (state_q == psfl_pkg::ST_WB) begin
			if (cnt_q != '0 && !found_v_q && ent_addr_q == addr_q) begin
				found_q <= e_q;
				fhead_q <= wb_head;
				fcnt_q  <= cnt_q;
			end
			if (cnt_q == '0 && !free_v_q) begin
				free_q <= e_q;
			end
		end
		if (state_q == psfl_pkg::ST_DECIDE) begin
			res_full_q  <= no_entry;
			res_flood_q <= no_entry ? (limit_q == '0) : over;
		end
		if (out_load) begin
			m_flood_q <= res_flood_q;
			m_full_q  <= res_full_q;
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input taken again before the previous attempt finished");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == psfl_pkg::ST_OUT))
		else $error("result beat raised outside the output step");

	a_time_read_live_entry: assert property (@(posedge clk) disable iff (!arst_n)
		time_re |-> (cnt_q != '0) && (state_q == psfl_pkg::ST_EXP))
		else $error("time ring read for an empty entry");

endmodule

`default_nettype wire
